>>> src/sfxc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfxc_pkg: shared types and codes for the sync frame XOR check forwarder
// Item structs for both channels, mode and status codes, defaults.
// ----------------------------------------------------------------------------
package sfxc_pkg;

  // Input item modes
  localparam logic [1:0] MODE_RX         = 2'd0;
  localparam logic [1:0] MODE_TX_DONE    = 2'd1;
  localparam logic [1:0] MODE_TX_TIMEOUT = 2'd2;
  localparam logic [1:0] MODE_OTHER      = 2'd3;

  // Result status codes, also used as the front-to-back command code
  localparam logic [1:0] ST_FWD  = 2'd0;
  localparam logic [1:0] ST_FAIL = 2'd1;
  localparam logic [1:0] ST_DROP = 2'd2;

  // Defaults
  localparam int          PAYLOAD_BYTES_DEF = 20;
  localparam logic [7:0]  FRAME_START_RESET = 8'hAA;

  typedef logic [1:0] cmd_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_byte;
    logic       last;
  } out_item_t;

  // Command queue status seen by the front end
  typedef struct packed {
    logic full;
    logic has_fwd;
  } cq_stat_t;

endpackage

>>> src/sfxc_cmdq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfxc_cmdq: two-entry command queue between front and back end
// Holds forward, fail and drop commands; reports whether a forward is queued.
// ----------------------------------------------------------------------------
module sfxc_cmdq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  sfxc_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output logic              head_valid,
  output sfxc_pkg::cmd_t    head_cmd,
  output sfxc_pkg::cq_stat_t stat
);
  import sfxc_pkg::*;

  cmd_t       entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;
  logic [1:0] slot_v;

  assign do_push = push && (cnt_r != 2'd2);
  assign do_pop  = pop && (cnt_r != 2'd0);

  // Occupancy of each slot
  always_comb begin
    slot_v[0] = (cnt_r == 2'd2) || ((cnt_r == 2'd1) && (rd_ptr_r == 1'b0));
    slot_v[1] = (cnt_r == 2'd2) || ((cnt_r == 2'd1) && (rd_ptr_r == 1'b1));
  end

  assign head_valid   = (cnt_r != 2'd0);
  assign head_cmd     = entry_r[rd_ptr_r];
  assign stat.full    = (cnt_r == 2'd2);
  assign stat.has_fwd = (slot_v[0] && (entry_r[0] == ST_FWD)) ||
                        (slot_v[1] && (entry_r[1] == ST_FWD));

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> src/sfxc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfxc_front: frame parser
// Hunts for sync, writes payload bytes, checks the XOR and issues commands.
// ----------------------------------------------------------------------------
module sfxc_front #(
  parameter int PAYLOAD_BYTES = sfxc_pkg::PAYLOAD_BYTES_DEF,
  parameter int IDX_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  output logic                full,
  input  sfxc_pkg::in_item_t  in_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [7:0]          cfg_data,
  input  sfxc_pkg::cq_stat_t  cq_stat,
  input  logic                back_active,
  output logic                cmd_push,
  output sfxc_pkg::cmd_t      cmd_code,
  output logic                mem_we,
  output logic [IDX_W-1:0]    mem_waddr,
  output logic [7:0]          mem_wdata
);
  import sfxc_pkg::*;

  localparam int CNT_W = $clog2(PAYLOAD_BYTES + 1);

  localparam logic [1:0] PH_HUNT  = 2'd0;
  localparam logic [1:0] PH_BODY  = 2'd1;
  localparam logic [1:0] PH_CHECK = 2'd2;

  logic [1:0]       phase_r, phase_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic             busy_r, busy_nxt;
  logic [7:0]       sync_r;
  logic             accept;
  logic             fwd_pending;

  // A payload byte may not overwrite the store while a burst still reads it
  assign fwd_pending = cq_stat.has_fwd || back_active;
  assign full        = cq_stat.full || ((phase_r == PH_BODY) && fwd_pending);
  assign accept      = push && !full;
  assign cfg_ready   = 1'b1;

  assign mem_waddr = cnt_r[IDX_W-1:0];
  assign mem_wdata = in_data.data_byte;

  // Parse one transaction
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    xor_nxt   = xor_r;
    busy_nxt  = busy_r;
    cmd_push  = 1'b0;
    cmd_code  = ST_FWD;
    mem_we    = 1'b0;
    if (accept) begin
      unique case (in_data.mode)
        MODE_TX_DONE, MODE_TX_TIMEOUT: begin
          busy_nxt = 1'b0;
        end
        MODE_RX: begin
          unique case (phase_r)
            PH_BODY: begin
              mem_we  = 1'b1;
              xor_nxt = xor_r ^ in_data.data_byte;
              cnt_nxt = cnt_r + CNT_W'(1);
              if (cnt_nxt == CNT_W'(PAYLOAD_BYTES)) begin
                phase_nxt = PH_CHECK;
              end
            end
            PH_CHECK: begin
              cmd_push  = 1'b1;
              phase_nxt = PH_HUNT;
              if (in_data.data_byte != xor_r) begin
                cmd_code = ST_FAIL;
              end else if (busy_r) begin
                cmd_code = ST_DROP;
              end else begin
                cmd_code = ST_FWD;
                busy_nxt = 1'b1;
              end
            end
            default: begin
              if (in_data.data_byte == sync_r) begin
                cnt_nxt   = '0;
                xor_nxt   = 8'h00;
                phase_nxt = PH_BODY;
              end else begin
                phase_nxt = PH_HUNT;
              end
            end
          endcase
        end
        default: begin
          busy_nxt = busy_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      cnt_r   <= '0;
      xor_r   <= 8'h00;
      busy_r  <= 1'b0;
      sync_r  <= FRAME_START_RESET;
    end else begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      xor_r   <= xor_nxt;
      busy_r  <= busy_nxt;
      if (cfg_valid && cfg_ready) begin
        sync_r <= cfg_data;
      end
    end
  end

endmodule

>>> src/sfxc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfxc_back: command executor
// Holds the payload store, turns commands into results and queues them out.
// ----------------------------------------------------------------------------
module sfxc_back #(
  parameter int PAYLOAD_BYTES = sfxc_pkg::PAYLOAD_BYTES_DEF,
  parameter int IDX_W         = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 mem_we,
  input  logic [IDX_W-1:0]     mem_waddr,
  input  logic [7:0]           mem_wdata,
  input  logic                 cmd_valid,
  input  sfxc_pkg::cmd_t       cmd_code,
  output logic                 cmd_pop,
  output logic                 active,
  output logic                 empty,
  input  logic                 pop,
  output sfxc_pkg::out_item_t  out_data
);
  import sfxc_pkg::*;

  logic [7:0]       mem [PAYLOAD_BYTES];
  logic [7:0]       rd_q;

  logic             act_r, act_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;

  logic             s1_v_r, s1_v_nxt;
  logic [1:0]       s1_st_r, s1_st_nxt;
  logic             s1_last_r, s1_last_nxt;

  out_item_t        ofifo_r [2];
  logic             owr_r, ord_r;
  logic [1:0]       ocnt_r, ocnt_nxt;
  logic             o_pop;
  out_item_t        s1_item;

  logic [1:0]       occ;
  logic             can_issue;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;

  // Issue only when the result path has a free slot for it
  assign occ       = ocnt_r + {1'b0, s1_v_r};
  assign can_issue = (occ < 2'd2);
  assign active    = act_r;

  // Sequence commands and burst reads
  always_comb begin
    act_nxt     = act_r;
    idx_nxt     = idx_r;
    s1_v_nxt    = 1'b0;
    s1_st_nxt   = s1_st_r;
    s1_last_nxt = s1_last_r;
    cmd_pop     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = idx_r;
    if (can_issue) begin
      if (act_r) begin
        rd_en       = 1'b1;
        s1_v_nxt    = 1'b1;
        s1_st_nxt   = ST_FWD;
        s1_last_nxt = (idx_r == IDX_W'(PAYLOAD_BYTES - 1));
        if (s1_last_nxt) begin
          act_nxt = 1'b0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end else if (cmd_valid) begin
        cmd_pop   = 1'b1;
        s1_v_nxt  = 1'b1;
        s1_st_nxt = cmd_code;
        if (cmd_code == ST_FWD) begin
          rd_en       = 1'b1;
          rd_addr     = '0;
          s1_last_nxt = (PAYLOAD_BYTES == 1);
          if (PAYLOAD_BYTES > 1) begin
            act_nxt = 1'b1;
            idx_nxt = IDX_W'(1);
          end
        end else begin
          s1_last_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      s1_v_r <= 1'b0;
    end else begin
      act_r  <= act_nxt;
      s1_v_r <= s1_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    s1_st_r   <= s1_st_nxt;
    s1_last_r <= s1_last_nxt;
  end

  // Payload store: one write port from the parser, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Assemble the result transaction
  always_comb begin
    s1_item.status   = s1_st_r;
    s1_item.out_byte = (s1_st_r == ST_FWD) ? rd_q : 8'h00;
    s1_item.last     = s1_last_r;
  end

  // Output queue
  assign o_pop    = pop && (ocnt_r != 2'd0);
  assign empty    = (ocnt_r == 2'd0);
  assign out_data = ofifo_r[ord_r];
  assign ocnt_nxt = ocnt_r + {1'b0, s1_v_r} - {1'b0, o_pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_r  <= 1'b0;
      ord_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      ocnt_r <= ocnt_nxt;
      if (s1_v_r) begin
        owr_r <= ~owr_r;
      end
      if (o_pop) begin
        ord_r <= ~ord_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      ofifo_r[owr_r] <= s1_item;
    end
  end

endmodule

>>> src/sync_frame_xor_check_forwarder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_xor_check_forwarder_unit: sync-framed payload forwarder
// Parses sync-framed, XOR-checked frames and forwards good payloads.
// ----------------------------------------------------------------------------
// Input transactions are taken at one per cycle; full rises when the two-entry
// command queue is full, and while a payload byte would overwrite a store that
// a forward burst is still reading out (from the check byte of a good frame
// until the last read of its burst is issued). Events and hunt bytes pass
// freely otherwise. A fail or drop gives one result via the command queue, the
// result stage and the output queue; a forward burst gives PAYLOAD_BYTES
// results via the registered store read, each issued only while the result
// stage and the two-entry output queue together still have a free slot.
module sync_frame_xor_check_forwarder_unit #(
  parameter int PAYLOAD_BYTES = sfxc_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  sfxc_pkg::in_item_t   in_data,
  output logic                 empty,
  input  logic                 pop,
  output sfxc_pkg::out_item_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);
  import sfxc_pkg::*;

  localparam int IDX_W = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;

  cq_stat_t         cq_stat;
  logic             cmd_push, cmd_pop, cmd_valid, back_active;
  cmd_t             cmd_in, cmd_head;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;

  sfxc_front #(.PAYLOAD_BYTES(PAYLOAD_BYTES), .IDX_W(IDX_W)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .full       (full),
    .in_data    (in_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .cq_stat    (cq_stat),
    .back_active(back_active),
    .cmd_push   (cmd_push),
    .cmd_code   (cmd_in),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata)
  );

  sfxc_cmdq u_cmdq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_cmd  (cmd_in),
    .pop       (cmd_pop),
    .head_valid(cmd_valid),
    .head_cmd  (cmd_head),
    .stat      (cq_stat)
  );

  sfxc_back #(.PAYLOAD_BYTES(PAYLOAD_BYTES), .IDX_W(IDX_W)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .mem_we   (mem_we),
    .mem_waddr(mem_waddr),
    .mem_wdata(mem_wdata),
    .cmd_valid(cmd_valid),
    .cmd_code (cmd_head),
    .cmd_pop  (cmd_pop),
    .active   (back_active),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

endmodule

>>> src/sfxc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfxc_checker: port-level checks for the forwarder
// Watches the result channel and reset behaviour; bound to the top level.
// ----------------------------------------------------------------------------
module sfxc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                empty,
  input logic                pop,
  input sfxc_pkg::out_item_t out_data
);
  import sfxc_pkg::*;

  // Reset drains the result queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  // Only the three defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.status == ST_FWD || out_data.status == ST_FAIL ||
                out_data.status == ST_DROP))
    else $error("undefined result status");

  // Fail and drop results are single, closed and carry no byte
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_data.status != ST_FWD) |-> (out_data.last && out_data.out_byte == 8'h00))
    else $error("fail or drop result malformed");

  // A waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_data)))
    else $error("waiting result changed before pop");

endmodule

bind sync_frame_xor_check_forwarder_unit sfxc_checker u_sfxc_checker (
  .clk     (clk),
  .rst_n   (rst_n),
  .empty   (empty),
  .pop     (pop),
  .out_data(out_data)
);

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: sync frame XOR check forwarder
// Drives sync-framed byte streams and radio events through the unit's input
// queue and predicts every forwarded byte and fail/drop status in a small
// scoreboard. Runs over several sync word settings, with bursty input
// traffic and an output side that stalls on patterns of its own.
// ----------------------------------------------------------------------------

// Predicts the unit's results and checks them in order of arrival
class frame_scoreboard;
  typedef enum logic [1:0] {PH_HUNT, PH_BODY, PH_CHECK} parse_phase_e;

  logic [7:0]             frame_sync;
  parse_phase_e           phase;
  int unsigned            byte_count;
  logic [7:0]             payload [sfxc_pkg::PAYLOAD_BYTES_DEF];
  logic [7:0]             frame_xor;
  bit                     tx_busy;
  sfxc_pkg::out_item_t    expected_q[$];
  int unsigned            mismatches;
  int unsigned            results_checked;
  int unsigned            frames_forwarded;
  int unsigned            checksum_fails;
  int unsigned            drops;

  function new();
    frame_sync       = sfxc_pkg::FRAME_START_RESET;
    phase            = PH_HUNT;
    byte_count       = 0;
    frame_xor        = '0;
    tx_busy          = 1'b0;
    mismatches       = 0;
    results_checked  = 0;
    frames_forwarded = 0;
    checksum_fails   = 0;
    drops            = 0;
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction

  function void add_status(logic [1:0] st);
    sfxc_pkg::out_item_t e;
    e.status   = st;
    e.out_byte = '0;
    e.last     = 1'b1;
    expected_q.push_back(e);
  endfunction

  // Advance the parser by one accepted input transaction
  function void note_input(sfxc_pkg::in_item_t it);
    sfxc_pkg::out_item_t e;
    case (it.mode)
      sfxc_pkg::MODE_TX_DONE, sfxc_pkg::MODE_TX_TIMEOUT: begin
        tx_busy = 1'b0;
      end
      sfxc_pkg::MODE_RX: begin
        case (phase)
          PH_BODY: begin
            if (byte_count < sfxc_pkg::PAYLOAD_BYTES_DEF) begin
              payload[byte_count] = it.data_byte;
              frame_xor = frame_xor ^ it.data_byte;
              byte_count++;
            end
            if (byte_count >= sfxc_pkg::PAYLOAD_BYTES_DEF) phase = PH_CHECK;
          end
          PH_CHECK: begin
            if (it.data_byte != frame_xor) begin
              add_status(sfxc_pkg::ST_FAIL);
              checksum_fails++;
            end else if (tx_busy) begin
              add_status(sfxc_pkg::ST_DROP);
              drops++;
            end else begin
              tx_busy = 1'b1;
              frames_forwarded++;
              for (int i = 0; i < sfxc_pkg::PAYLOAD_BYTES_DEF; i++) begin
                e.status   = sfxc_pkg::ST_FWD;
                e.out_byte = payload[i];
                e.last     = (i == sfxc_pkg::PAYLOAD_BYTES_DEF - 1);
                expected_q.push_back(e);
              end
            end
            phase = PH_HUNT;
          end
          default: begin
            if (it.data_byte == frame_sync) begin
              byte_count = 0;
              frame_xor  = '0;
              phase      = PH_BODY;
            end else begin
              phase = PH_HUNT;
            end
          end
        endcase
      end
      default: ;  // other radio events leave everything as it is
    endcase
  endfunction

  task report(string msg);
    mismatches++;
    if (mismatches <= 100) $display("%t MISMATCH: %s", $realtime, msg);
  endtask

  // Compare one popped result with the oldest expectation
  task check_result(sfxc_pkg::out_item_t got);
    sfxc_pkg::out_item_t e;
    if (expected_q.size() == 0) begin
      report($sformatf("unexpected result status=%0d byte=%02h last=%0d",
                       got.status, got.out_byte, got.last));
    end else begin
      e = expected_q.pop_front();
      if (got.status !== e.status)
        report($sformatf("result %0d status: expected %0d, got %0d",
                         results_checked, e.status, got.status));
      if (got.out_byte !== e.out_byte)
        report($sformatf("result %0d out_byte: expected %02h, got %02h",
                         results_checked, e.out_byte, got.out_byte));
      if (got.last !== e.last)
        report($sformatf("result %0d last: expected %0d, got %0d",
                         results_checked, e.last, got.last));
    end
    results_checked++;
  endtask
endclass

module testbench;
  import sfxc_pkg::*;

  typedef enum int {POP_ALWAYS, POP_RANDOM, POP_THIRD, POP_STALLS} pop_style_e;

  localparam int SETTLE_CYCLES = 16;

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  in_item_t   in_data;
  logic       empty;
  logic       pop;
  out_item_t  out_data;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [7:0] cfg_data;

  frame_scoreboard sb;
  bit              sender_gaps;
  int unsigned     burst_left;
  int unsigned     sent_items;
  logic [7:0]      mid_sync;
  logic [1:0]      event_modes [3] = '{MODE_TX_DONE, MODE_TX_TIMEOUT, MODE_OTHER};

  sync_frame_xor_check_forwarder_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .in_data   (in_data),
    .empty     (empty),
    .pop       (pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 4 ns clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hand one transaction to the unit, with a random gap between bursts
  task automatic send_item(in_item_t it);
    int unsigned gap;
    if (sender_gaps && burst_left == 0) begin
      gap        = $urandom_range(1, 6);
      burst_left = $urandom_range(1, 16);
      @(negedge clk);
      push <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    push    <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_input(it);
    sent_items++;
  endtask

  task automatic send_rx(logic [7:0] b);
    send_item('{mode: MODE_RX, data_byte: b});
  endtask

  // Occasionally slip a radio event in between frame bytes
  task automatic maybe_event();
    if ($urandom_range(0, 11) == 0)
      send_item('{mode: event_modes[$urandom_range(0, 2)], data_byte: 8'($urandom)});
  endtask

  // Sync byte, n_payload bytes and optionally a check byte (good or corrupted)
  task automatic send_frame(int n_payload, bit bad_check, bit with_check, bit pin_extremes);
    logic [7:0] sum;
    logic [7:0] b;
    sum = '0;
    send_rx(sb.frame_sync);
    for (int i = 0; i < n_payload; i++) begin
      if (!pin_extremes) maybe_event();
      b = 8'($urandom);
      if (pin_extremes && i == 0) b = 8'h00;
      if (pin_extremes && i == 1) b = 8'hFF;
      if (pin_extremes && i == 2) b = sb.frame_sync;  // sync inside the payload
      send_rx(b);
      sum = sum ^ b;
    end
    if (with_check) begin
      if (!pin_extremes) maybe_event();
      send_rx(bad_check ? sum ^ 8'($urandom_range(1, 255)) : sum);
    end
  endtask

  // Mostly well-formed frames, the rest events, noise and broken frames
  task automatic run_random(int unsigned n_items);
    int unsigned target;
    int unsigned pick;
    target = sent_items + n_items;
    while (sent_items < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)
        send_frame(PAYLOAD_BYTES_DEF, $urandom_range(0, 3) == 0, 1'b1, 1'b0);
      else if (pick < 72)
        send_frame($urandom_range(0, PAYLOAD_BYTES_DEF - 1), 1'b0, 1'b0, 1'b0);
      else if (pick < 90)
        send_item('{mode: event_modes[$urandom_range(0, 2)], data_byte: 8'($urandom)});
      else
        send_rx(8'($urandom));
    end
  endtask

  // Hold off until every expected result is out and the pipeline has settled
  task automatic wait_drained();
    @(negedge clk);
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_sync(logic [7:0] w);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.frame_sync = w;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Output side: pop on a randomly chosen pattern that is picked anew when its run ends
  initial begin : pop_pattern
    pop_style_e  style;
    int unsigned left;
    int unsigned stall;
    pop   = 1'b0;
    style = POP_ALWAYS;
    left  = 0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        style = pop_style_e'($urandom_range(0, 3));
        left  = $urandom_range(20, 80);
      end
      left--;
      case (style)
        POP_ALWAYS: pop <= 1'b1;
        POP_RANDOM: pop <= 1'($urandom_range(0, 1));
        POP_THIRD:  pop <= (left % 3 == 0);
        default: begin
          if (stall > 0) begin
            stall--;
            pop <= 1'b0;
          end else begin
            pop <= 1'b1;
            if ($urandom_range(0, 5) == 0) stall = $urandom_range(1, 15);
          end
        end
      endcase
    end
  end

  // Check every popped result
  always @(posedge clk) begin
    if (rst_n && pop && !empty) sb.check_result(out_data);
  end

  initial begin : stimulus
    sb          = new();
    push        = 1'b0;
    in_data     = '0;
    cfg_valid   = 1'b0;
    cfg_data    = '0;
    rst_n       = 1'b0;
    sender_gaps = 1'b1;
    burst_left  = 0;
    sent_items  = 0;
    mid_sync    = 8'($urandom);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: every event kind, hunt bytes at both extremes, one good frame
    send_item('{mode: MODE_TX_DONE, data_byte: 8'hFF});
    send_item('{mode: MODE_TX_TIMEOUT, data_byte: 8'h00});
    send_item('{mode: MODE_OTHER, data_byte: 8'hFF});
    send_rx(8'h00);
    send_rx(8'hFF);
    send_frame(PAYLOAD_BYTES_DEF, 1'b0, 1'b1, 1'b1);

    // Random traffic under several sync words; one phase with no input gaps
    wait_drained();
    write_sync(8'h00);
    run_random(32);
    wait_drained();
    write_sync(8'hFF);
    run_random(32);
    wait_drained();
    write_sync(mid_sync);
    sender_gaps = 1'b0;
    run_random(32);
    wait_drained();
    write_sync(FRAME_START_RESET);
    sender_gaps = 1'b1;
    run_random(32);
    wait_drained();

    $display("Run covered %0d input transactions under sync words 0xAA, 0x00, 0xFF, 0x%02h",
             sent_items, mid_sync);
    $display("Checked %0d results: %0d frames forwarded, %0d checksum fails, %0d drops",
             sb.results_checked, sb.frames_forwarded, sb.checksum_fails, sb.drops);
    if (sb.mismatches == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

endmodule

>>> sim.f
src/sfxc_pkg.sv
src/sfxc_cmdq.sv
src/sfxc_front.sv
src/sfxc_back.sv
src/sync_frame_xor_check_forwarder_unit.sv
src/sfxc_checker.sv
sim/testbench.sv
